>>> hw/rtl/tmcl_pkg.sv
// shared types, constants and tables for the mip chain layout unit
package tmcl_pkg;

  // fixed limits of the layout
  localparam int MAX_MIP_LEVELS = 15;
  localparam int MAX_DIMENSION  = 16384;
  localparam int OFFSET_ALIGN   = 16;

  // level counter width, enough for indexes 0 .. MAX_MIP_LEVELS-1
  localparam int LVL_W = (MAX_MIP_LEVELS > 1) ? $clog2(MAX_MIP_LEVELS) : 1;

  // block count by reciprocal: q = (n * ceil(2^19 / b)) >> 19, exact for n < 2^15, b <= 16
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 20;

  // stream word widths
  localparam int IN_W  = 64;
  localparam int OUT_W = 272;

  // configuration register indexes
  localparam logic [1:0] CFG_BLOCK_BYTES  = 2'd0;
  localparam logic [1:0] CFG_BLOCK_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_HEIGHT = 2'd2;

  // offset alignment mask
  localparam logic [55:0] ALIGN_MASK = 56'(OFFSET_ALIGN - 1);

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic blk;
    logic pitch;
    logic slice;
    logic part;
    logic sum;
    logic fin;
    logic emit;
  } tmcl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic out_free;
  } tmcl_status_t;

  // block size register read as 1 .. 16
  function automatic logic [4:0] clamp_block(input logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (v > 5'd16) begin
      r = 5'd16;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ceil(2^19 / b) for block sizes 1 .. 16
  function automatic logic [RECIP_W-1:0] recip(input logic [4:0] b);
    logic [RECIP_W-1:0] r;
    case (b)
      5'd1:    r = 20'd524288;
      5'd2:    r = 20'd262144;
      5'd3:    r = 20'd174763;
      5'd4:    r = 20'd131072;
      5'd5:    r = 20'd104858;
      5'd6:    r = 20'd87382;
      5'd7:    r = 20'd74899;
      5'd8:    r = 20'd65536;
      5'd9:    r = 20'd58255;
      5'd10:   r = 20'd52429;
      5'd11:   r = 20'd47663;
      5'd12:   r = 20'd43691;
      5'd13:   r = 20'd40330;
      5'd14:   r = 20'd37450;
      5'd15:   r = 20'd34953;
      5'd16:   r = 20'd32768;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/texture_mip_chain_layout_unit.sv
// top level of the mip chain layout unit: config registers, sequencer, datapath
//
// Each request describes one texture and yields one result per mip level, the
// final one marked with tlast. A level goes through the datapath steps in order
// (block counts by reciprocal multiply, pitches, slice size, the level volume
// as two partial products, their sum, the end offset, then the result load);
// the result load waits until the output register is free. The next request is
// taken as soon as the last level is loaded into the output register. Block
// size registers are read as 1 .. 16 and are meant to be written while no
// texture is in progress.
module texture_mip_chain_layout_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // width, height, depth, array_layers, level_count, zero pad
  input  logic [tmcl_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // level_offset, blk_cols, blk_rows, padded_width, padded_height, level_width,
  // level_height, level_depth, row_bytes, slice_bytes, total_size, zero pad
  output logic [tmcl_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [4:0]                  cfg_data
);
  import tmcl_pkg::*;

  logic [4:0]   block_bytes;
  logic [4:0]   block_width;
  logic [4:0]   block_height;
  tmcl_cmd_t    cmd;
  tmcl_status_t status;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes  <= 5'd4;
      block_width  <= 5'd1;
      block_height <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCK_BYTES:  block_bytes  <= cfg_data;
        CFG_BLOCK_WIDTH:  block_width  <= cfg_data;
        CFG_BLOCK_HEIGHT: block_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  tmcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and result register
  tmcl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_data      (s_axis_tdata),
    .block_bytes  (clamp_block(block_bytes)),
    .block_width  (clamp_block(block_width)),
    .block_height (clamp_block(block_height)),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_data     (m_axis_tdata),
    .out_last     (m_axis_tlast)
  );

endmodule

>>> hw/rtl/tmcl_ctrl.sv
// sequencer that walks each texture through its mip levels
module tmcl_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tmcl_pkg::tmcl_status_t   status,
  output tmcl_pkg::tmcl_cmd_t      cmd
);
  import tmcl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLK   = 3'd1;
  localparam logic [2:0] S_PITCH = 3'd2;
  localparam logic [2:0] S_SLICE = 3'd3;
  localparam logic [2:0] S_PART  = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one step of the level sequence per cycle, holding in the emit step until the result register is free
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_BLK;
        end
      end
      S_BLK: begin
        cmd.blk    = 1'b1;
        state_next = S_PITCH;
      end
      S_PITCH: begin
        cmd.pitch  = 1'b1;
        state_next = S_SLICE;
      end
      S_SLICE: begin
        cmd.slice  = 1'b1;
        state_next = S_PART;
      end
      S_PART: begin
        cmd.part   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last ? S_IDLE : S_BLK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // new texture only between textures
  assign in_ready = (state == S_IDLE);

endmodule

>>> hw/rtl/tmcl_datapath.sv
// per-level layout arithmetic and the result register
module tmcl_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tmcl_pkg::tmcl_cmd_t         cmd,
  output tmcl_pkg::tmcl_status_t      status,
  input  logic [tmcl_pkg::IN_W-1:0]   in_data,
  input  logic [4:0]                  block_bytes,
  input  logic [4:0]                  block_width,
  input  logic [4:0]                  block_height,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmcl_pkg::OUT_W-1:0]  out_data,
  output logic                        out_last
);
  import tmcl_pkg::*;

  // input fields
  logic [14:0] w_in;
  logic [14:0] h_in;
  logic [11:0] d_in;
  logic [11:0] layers_in;
  logic [3:0]  req_in;
  logic [14:0] w_cl;
  logic [14:0] h_cl;
  logic [11:0] d_cl;
  logic [11:0] layers_cl;

  // per-texture and per-level registers
  logic [14:0]      w;
  logic [14:0]      h;
  logic [11:0]      d;
  logic [11:0]      layers;
  logic [3:0]       req;
  logic [LVL_W-1:0] lvl;
  logic [55:0]      offset;
  logic [14:0]      bx;
  logic [14:0]      by;
  logic [14:0]      row_len;
  logic [14:0]      img_h;
  logic [18:0]      row_bytes;
  logic [28:0]      bxy;
  logic [23:0]      ld;
  logic [32:0]      slice;
  logic [40:0]      p_lo;
  logic [39:0]      p_hi;
  logic [55:0]      vol;
  logic [55:0]      end_off;

  // combinational products
  logic [15:0]        nx;
  logic [15:0]        ny;
  logic [RECIP_W-1:0] recip_x;
  logic [RECIP_W-1:0] recip_y;
  logic [35:0]        prod_x;
  logic [35:0]        prod_y;
  logic [19:0]        rl_full;
  logic [19:0]        ih_full;
  logic [19:0]        rp_full;
  logic [29:0]        bxy_full;
  logic [33:0]        slice_full;
  logic [56:0]        sum_full;

  // level control
  logic [LVL_W:0] lvl_p1;
  logic           hit_max;
  logic           all_one;
  logic           last;

  // unpack and clamp the request; depth and layer count only need the zero case
  assign w_in      = in_data[14:0];
  assign h_in      = in_data[29:15];
  assign d_in      = in_data[41:30];
  assign layers_in = in_data[53:42];
  assign req_in    = in_data[57:54];

  always_comb begin
    if (w_in == 15'd0) begin
      w_cl = 15'd1;
    end else if ({1'b0, w_in} > 16'(MAX_DIMENSION)) begin
      w_cl = 15'(MAX_DIMENSION);
    end else begin
      w_cl = w_in;
    end
    if (h_in == 15'd0) begin
      h_cl = 15'd1;
    end else if ({1'b0, h_in} > 16'(MAX_DIMENSION)) begin
      h_cl = 15'(MAX_DIMENSION);
    end else begin
      h_cl = h_in;
    end
    d_cl      = (d_in == 12'd0) ? 12'd1 : d_in;
    layers_cl = (layers_in == 12'd0) ? 12'd1 : layers_in;
  end

  // block counts by reciprocal multiply
  assign nx      = 16'(w) + 16'(block_width) - 16'd1;
  assign ny      = 16'(h) + 16'(block_height) - 16'd1;
  assign recip_x = recip(block_width);
  assign recip_y = recip(block_height);
  assign prod_x  = nx * recip_x;
  assign prod_y  = ny * recip_y;

  // padded sizes and pitches
  assign rl_full    = bx * block_width;
  assign ih_full    = by * block_height;
  assign rp_full    = bx * block_bytes;
  assign bxy_full   = bx * by;
  assign slice_full = bxy * block_bytes;

  // level volume from two partial products
  assign sum_full = 57'(p_lo) + {p_hi, 17'd0};

  // last level: requested count, full chain reached 1x1x1, or level limit
  assign lvl_p1  = {1'b0, lvl} + (LVL_W+1)'(1);
  assign hit_max = (lvl_p1 == (LVL_W+1)'(MAX_MIP_LEVELS));
  assign all_one = (w == 15'd1) && (h == 15'd1) && (d == 12'd1);
  assign last    = hit_max || ((req == 4'd0) ? all_one : (lvl_p1 == (LVL_W+1)'(req)));

  assign status.last     = last;
  assign status.out_free = !out_valid || out_ready;

  // level sequence registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w      <= w_cl;
      h      <= h_cl;
      d      <= d_cl;
      layers <= layers_cl;
      req    <= req_in;
      lvl    <= '0;
      offset <= '0;
    end
    if (cmd.blk) begin
      bx <= prod_x[RECIP_SHIFT +: 15];
      by <= prod_y[RECIP_SHIFT +: 15];
    end
    if (cmd.pitch) begin
      row_len   <= rl_full[14:0];
      img_h     <= ih_full[14:0];
      row_bytes <= rp_full[18:0];
      bxy       <= bxy_full[28:0];
      ld        <= layers * d;
    end
    if (cmd.slice) begin
      slice <= slice_full[32:0];
    end
    if (cmd.part) begin
      p_lo <= slice[16:0] * ld;
      p_hi <= slice[32:17] * ld;
    end
    if (cmd.sum) begin
      vol <= sum_full[55:0];
    end
    if (cmd.fin) begin
      end_off <= offset + vol;
    end
    // advance to the next level: align the offset, step the index, halve with a floor of one
    if (cmd.emit) begin
      offset <= (end_off + ALIGN_MASK) & ~ALIGN_MASK;
      lvl    <= lvl + LVL_W'(1);
      w      <= (w[14:1] == 14'd0) ? 15'd1 : {1'b0, w[14:1]};
      h      <= (h[14:1] == 14'd0) ? 15'd1 : {1'b0, h[14:1]};
      d      <= (d[11:1] == 11'd0) ? 12'd1 : {1'b0, d[11:1]};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {6'd0, end_off, slice, row_bytes, d, h, w, img_h, row_len, by, bx, offset};
      out_last <= last;
    end
  end

  // a result never overwrites one that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // the level index stays inside the chain limit
  a_lvl_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> ({1'b0, lvl} < (LVL_W+1)'(MAX_MIP_LEVELS)))
    else $error("level index past the chain limit");

  // a new texture starts at level zero and offset zero
  a_start_init: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (lvl == '0 && offset == '0))
    else $error("texture did not start at level zero");

endmodule

>>> dv/mip_layout_checker.sv
// checker for the mip chain layout unit: per-level prediction and result comparison
`timescale 1ns / 1ps

module mip_layout_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  // width, height, depth, array_layers, level_count, zero pad
  input  logic [tmcl_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // level_offset, blk_cols, blk_rows, padded_width, padded_height, level_width,
  // level_height, level_depth, row_bytes, slice_bytes, total_size, zero pad
  input  logic [tmcl_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [4:0]                  cfg_data,
  output int                          mismatches,
  output int                          outstanding
);

  localparam logic [63:0] MASK56 = 64'h00ff_ffff_ffff_ffff;

  // one predicted mip level
  typedef struct {
    logic [55:0] level_offset;
    logic [14:0] blk_cols;
    logic [14:0] blk_rows;
    logic [14:0] padded_width;
    logic [14:0] padded_height;
    logic [14:0] level_width;
    logic [14:0] level_height;
    logic [11:0] level_depth;
    logic [18:0] row_bytes;
    logic [32:0] slice_bytes;
    logic [55:0] total_size;
    logic        last;
  } level_layout_t;

  level_layout_t level_q[$];
  logic [4:0]    blk_bytes_reg;
  logic [4:0]    blk_width_reg;
  logic [4:0]    blk_height_reg;
  int            results_seen;

  // zero reads as 1, anything above hi saturates
  function automatic logic [63:0] saturate(input logic [63:0] v, input logic [63:0] hi);
    if (v == 64'd0) begin
      return 64'd1;
    end
    return (v > hi) ? hi : v;
  endfunction

  // expected layout of every level of one texture request
  function automatic void plan_levels(input logic [63:0] word);
    logic [63:0]   w, h, d, layers, count, bb, bw, bh, biggest;
    logic [63:0]   offset, bx, by, slice, span;
    level_layout_t lv;
    bb = saturate(blk_bytes_reg, 16);
    bw = saturate(blk_width_reg, 16);
    bh = saturate(blk_height_reg, 16);
    w = saturate(word[14:0], tmcl_pkg::MAX_DIMENSION);
    h = saturate(word[29:15], tmcl_pkg::MAX_DIMENSION);
    d = saturate(word[41:30], tmcl_pkg::MAX_DIMENSION);
    layers = saturate(word[53:42], 4096);
    count = word[57:54];
    // full chain: bit length of the largest extent
    if (count == 64'd0) begin
      biggest = w;
      if (h > biggest) biggest = h;
      if (d > biggest) biggest = d;
      while (biggest != 64'd0) begin
        count++;
        biggest >>= 1;
      end
    end
    if (count > tmcl_pkg::MAX_MIP_LEVELS) count = tmcl_pkg::MAX_MIP_LEVELS;
    offset = 64'd0;
    for (int k = 0; k < count; k++) begin
      bx = (w + bw - 1) / bw;
      by = (h + bh - 1) / bh;
      slice = bx * by * bb;
      offset = (((offset + tmcl_pkg::OFFSET_ALIGN - 1) / tmcl_pkg::OFFSET_ALIGN)
               * tmcl_pkg::OFFSET_ALIGN) & MASK56;
      span = (offset + slice * layers * d) & MASK56;
      lv.level_offset  = offset[55:0];
      lv.blk_cols      = bx[14:0];
      lv.blk_rows      = by[14:0];
      lv.padded_width  = 15'(bx * bw);
      lv.padded_height = 15'(by * bh);
      lv.level_width   = w[14:0];
      lv.level_height  = h[14:0];
      lv.level_depth   = d[11:0];
      lv.row_bytes     = 19'(bx * bb);
      lv.slice_bytes   = slice[32:0];
      lv.total_size    = span[55:0];
      lv.last          = (k + 1 == count);
      level_q.push_back(lv);
      offset = span;
      w = (w > 1) ? w >> 1 : 64'd1;
      h = (h > 1) ? h >> 1 : 64'd1;
      d = (d > 1) ? d >> 1 : 64'd1;
    end
  endfunction

  task automatic report(input string what);
    $display("%0t ns: mismatch on result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want_v);
    if (got !== want_v) begin
      report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want_v));
    end
  endtask

  // watch config writes, requests and results
  always @(posedge clk) begin : watch
    level_layout_t want;
    if (rst) begin
      blk_bytes_reg  = 5'd4;
      blk_width_reg  = 5'd1;
      blk_height_reg = 5'd1;
      results_seen   = 0;
      level_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmcl_pkg::CFG_BLOCK_BYTES:  blk_bytes_reg  = cfg_data;
          tmcl_pkg::CFG_BLOCK_WIDTH:  blk_width_reg  = cfg_data;
          tmcl_pkg::CFG_BLOCK_HEIGHT: blk_height_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        plan_levels(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (level_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = level_q.pop_front();
          check_field("level_offset", m_axis_tdata[55:0], want.level_offset);
          check_field("blk_cols", m_axis_tdata[70:56], want.blk_cols);
          check_field("blk_rows", m_axis_tdata[85:71], want.blk_rows);
          check_field("padded_width", m_axis_tdata[100:86], want.padded_width);
          check_field("padded_height", m_axis_tdata[115:101], want.padded_height);
          check_field("level_width", m_axis_tdata[130:116], want.level_width);
          check_field("level_height", m_axis_tdata[145:131], want.level_height);
          check_field("level_depth", m_axis_tdata[157:146], want.level_depth);
          check_field("row_bytes", m_axis_tdata[176:158], want.row_bytes);
          check_field("slice_bytes", m_axis_tdata[209:177], want.slice_bytes);
          check_field("total_size", m_axis_tdata[265:210], want.total_size);
          check_field("last", m_axis_tlast, want.last);
        end
        results_seen++;
      end
    end
    outstanding <= level_q.size();
  end

endmodule

>>> dv/texture_mip_chain_layout_unit_test.sv
// testbench top for the mip chain layout unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module texture_mip_chain_layout_unit_test;

  // index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // width, height, depth, array_layers, level_count, zero pad
  logic [tmcl_pkg::IN_W-1:0]   s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // level_offset, blk_cols, blk_rows, padded_width, padded_height, level_width,
  // level_height, level_depth, row_bytes, slice_bytes, total_size, zero pad
  logic [tmcl_pkg::OUT_W-1:0]  m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index = 2'd0;
  logic [4:0]                  cfg_data = 5'd0;

  int   mismatches;
  int   outstanding;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_active = 1'b0;
  logic burst_req = 1'b0;

  texture_mip_chain_layout_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mip_layout_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // output side backpressure
  always @(posedge clk) begin
    m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  // long output stall so the unit fills up and blocks new requests
  initial begin
    wait (burst_req);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk);
    hold_active <= 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("texture_mip_chain_layout_unit verification failed");
    $finish;
  end

  task automatic send_texture(input int w, input int h, input int d, input int layers,
                              input int levels);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, 4'(levels), 12'(layers), 12'(d), 15'(h), 15'(w)};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // mostly small extents, sometimes full range or saturation edges
  function automatic int pick_extent();
    case ($urandom_range(9))
      0: return $urandom_range(0, 32767);
      1: begin
        case ($urandom_range(3))
          0: return 0;
          1: return 16384;
          2: return 16385;
          default: return 32767;
        endcase
      end
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(5))
      0: return $urandom_range(0, 4095);
      1: return $urandom_range(0, 8);
      default: return 1;
    endcase
  endfunction

  task automatic send_random_texture();
    int w, h, d, layers;
    w = pick_extent();
    h = pick_extent();
    d = pick_count();
    layers = pick_count();
    send_texture(w, h, d, layers, $urandom_range(0, 15));
  endtask

  // hold requests until every predicted level has come back
  task automatic await_all_levels();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_block(input logic [4:0] bytes, input logic [4:0] bw,
                               input logic [4:0] bh, input bit poke_unused);
    if (poke_unused) write_reg(CFG_UNUSED, 5'($urandom_range(31)));
    write_reg(tmcl_pkg::CFG_BLOCK_BYTES, bytes);
    write_reg(tmcl_pkg::CFG_BLOCK_WIDTH, bw);
    write_reg(tmcl_pkg::CFG_BLOCK_HEIGHT, bh);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (items) send_random_texture();
    await_all_levels();
  endtask

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners at reset block settings
    send_texture(1, 1, 1, 1, 0);
    // zero extents read as 1
    send_texture(0, 0, 0, 0, 0);
    // levels past the chain repeat at 1x1x1
    send_texture(0, 0, 0, 0, 15);
    send_texture(16384, 16384, 1, 1, 0);
    // every field bit high, oversized extents saturate
    send_texture(32767, 32767, 4095, 4095, 15);
    send_texture(16385, 1, 1, 1, 0);
    // chain length set by depth
    send_texture(1, 1, 2048, 1, 0);
    send_texture(1, 16384, 1, 4095, 1);
    send_texture(21845, 10922, 2730, 1365, 5);
    send_texture(10922, 21845, 1365, 2730, 10);
    send_texture(3, 5, 7, 2, 4);
    send_texture(100, 37, 1, 6, 3);
    send_texture(1, 1, 1, 1, 1);
    send_texture(8, 8, 8, 8, 2);
    send_texture(64, 1, 1, 3, 0);
    send_texture(1, 64, 1, 1, 0);
    await_all_levels();

    // random textures across block settings and idling mixes
    program_block(5'd16, 5'd16, 5'd16, 1'b0);
    run_phase(0, 0, 16);
    program_block(5'd1, 5'd1, 5'd1, 1'b0);
    run_phase(51, 0, 16);
    // zero registers read as 1, unknown index ignored
    program_block(5'd0, 5'd0, 5'd0, 1'b1);
    run_phase(0, 51, 16);
    // oversized registers read as 16
    program_block(5'd31, 5'd31, 5'd31, 1'b1);
    run_phase(7, 7, 16);
    program_block(5'($urandom_range(31)), 5'($urandom_range(31)),
                  5'($urandom_range(31)), 1'b0);
    run_phase(51, 0, 16);
    program_block(5'd16, 5'd4, 5'd4, 1'b0);
    run_phase(0, 51, 16);
    program_block(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                  5'($urandom_range(1, 16)), 1'b1);
    run_phase(7, 7, 16);

    // back-to-back requests against a long output stall
    program_block(5'd8, 5'd4, 5'd4, 1'b0);
    burst_req <= 1'b1;
    run_phase(0, 0, 12);

    repeat (120) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("texture_mip_chain_layout_unit verification clean");
    end else begin
      $display("texture_mip_chain_layout_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tmcl_pkg.sv
hw/rtl/tmcl_ctrl.sv
hw/rtl/tmcl_datapath.sv
hw/rtl/texture_mip_chain_layout_unit.sv
dv/mip_layout_checker.sv
dv/texture_mip_chain_layout_unit_test.sv
